// File: rtl/lmr_pkg.sv
`timescale 1ns / 1ps

package lmr_pkg;

    localparam int BYTES_PER_FRAME = 5;

    localparam logic [1:0] CFG_TIMEOUT_TICKS    = 2'd0;
    localparam logic [1:0] CFG_CHUNK_LENGTH     = 2'd1;
    localparam logic [1:0] CFG_SUBSCRIBED_IDS   = 2'd2;
    localparam logic [1:0] CFG_SUBSCRIBED_COUNT = 2'd3;

    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd5000;
    localparam logic [15:0] CHUNK_LENGTH_RESET  = 16'd64;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_COMPLETE = 3'd1;
    localparam logic [2:0] EV_CHUNK    = 3'd2;
    localparam logic [2:0] EV_SEQ_ERR  = 3'd3;
    localparam logic [2:0] EV_TIMEOUT  = 3'd4;

    typedef struct packed {
        logic       command;
        logic [7:0] channel_id;
        logic [7:0] sequence_req;
        logic [7:0] payload_0;
        logic [7:0] payload_1;
        logic [7:0] payload_2;
        logic [7:0] payload_3;
        logic [7:0] payload_4;
    } frame_t;

    typedef struct packed {
        logic        has_byte;
        logic [7:0]  data_byte;
        logic [2:0]  event_res;
        logic [15:0] chunk_count;
        logic [7:0]  event_stream;
        logic        last;
    } result_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_SEQ_ERR,
        KIND_TIMEOUT
    } cmd_kind_t;

    // one classified frame or tick handed from front to back
    typedef struct packed {
        cmd_kind_t                       kind;
        logic [7:0]                      stream;
        logic [2:0]                      nbytes;
        logic                            complete;
        logic [BYTES_PER_FRAME-1:0][7:0] data;
    } cmd_t;

endpackage

// File: rtl/long_message_reassembler_unit.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake                       Payload
// frame    in         frame_valid / frame_stall       lmr_pkg::frame_t
// result   out        result_valid / result_stall     lmr_pkg::result_t
// config   in         cfg_wr_en (no wait)             cfg_index, cfg_data
// A data frame yields 1 to 5 result beats, one beat per cycle while result_stall is low.
// Headers, ignored frames and plain ticks give no beat.
// Sequence error and timeout each give one event-only beat.
// Reset: registers return to their defaults, no reception open, queue empty.
// result_stall holds the output register; frame_stall rises when the queue is full.

module long_message_reassembler_unit #(
    parameter int MAX_STREAMS = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              frame_valid,
    input  lmr_pkg::frame_t   frame,
    output logic              frame_stall,
    output logic              result_valid,
    output lmr_pkg::result_t  result,
    input  logic              result_stall,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import lmr_pkg::*;

    logic [15:0]              timeout_ticks_reg;
    logic [15:0]              chunk_length_reg;
    logic [MAX_STREAMS*8-1:0] sub_ids_reg;
    logic [3:0]               sub_count_reg;

    logic push, full, head_valid, pop;
    cmd_t push_cmd, head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_TICKS_RESET;
            chunk_length_reg  <= CHUNK_LENGTH_RESET;
            sub_ids_reg       <= '0;
            sub_count_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_TIMEOUT_TICKS:    timeout_ticks_reg <= cfg_data[15:0];
                CFG_CHUNK_LENGTH:     chunk_length_reg  <= cfg_data[15:0];
                CFG_SUBSCRIBED_IDS:   sub_ids_reg       <= cfg_data[MAX_STREAMS*8-1:0];
                CFG_SUBSCRIBED_COUNT: sub_count_reg     <= cfg_data[3:0];
                default:              sub_count_reg     <= sub_count_reg;
            endcase
        end
    end

    lmr_front #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_valid   (frame_valid),
        .frame         (frame),
        .frame_stall   (frame_stall),
        .timeout_ticks (timeout_ticks_reg),
        .sub_ids       (sub_ids_reg),
        .sub_count     (sub_count_reg),
        .push          (push),
        .cmd           (push_cmd),
        .full          (full)
    );

    lmr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (push_cmd),
        .full     (full),
        .rd_valid (head_valid),
        .rd_data  (head),
        .rd_en    (pop)
    );

    lmr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .chunk_length (chunk_length_reg),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

// File: rtl/lmr_front.sv
`timescale 1ns / 1ps

module lmr_front #(
    parameter int MAX_STREAMS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       frame_valid,
    input  lmr_pkg::frame_t            frame,
    output logic                       frame_stall,
    input  logic [15:0]                timeout_ticks,
    input  logic [MAX_STREAMS*8-1:0]   sub_ids,
    input  logic [3:0]                 sub_count,
    output logic                       push,
    output lmr_pkg::cmd_t              cmd,
    input  logic                       full
);
    import lmr_pkg::*;

    logic        receiving_reg, receiving_next;
    logic [7:0]  active_stream_reg, active_stream_next;
    logic [7:0]  expected_seq_reg, expected_seq_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        zero_len_reg, zero_len_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;

    logic accept;
    logic hit;

    assign frame_stall = full;
    assign accept      = frame_valid && !full;

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < MAX_STREAMS; k++)
        begin
            if ((4'(k) < sub_count) && (sub_ids[8*k +: 8] == frame.channel_id))
                hit = 1'b1;
        end
    end

    always_comb
    begin
        receiving_next     = receiving_reg;
        active_stream_next = active_stream_reg;
        expected_seq_next  = expected_seq_reg;
        remaining_next     = remaining_reg;
        zero_len_next      = zero_len_reg;
        idle_ticks_next    = idle_ticks_reg;
        push               = 1'b0;
        cmd.kind           = KIND_DATA;
        cmd.stream         = active_stream_reg;
        cmd.nbytes         = 3'(BYTES_PER_FRAME);
        cmd.complete       = 1'b0;
        cmd.data           = {frame.payload_4, frame.payload_3, frame.payload_2,
                              frame.payload_1, frame.payload_0};
        if (accept)
        begin
            if (frame.command)
            begin
                if (idle_ticks_reg != 16'hFFFF)
                    idle_ticks_next = idle_ticks_reg + 16'd1;
                if (receiving_reg && (idle_ticks_next >= timeout_ticks))
                begin
                    push           = 1'b1;
                    cmd.kind       = KIND_TIMEOUT;
                    receiving_next = 1'b0;
                end
            end
            else
            begin
                idle_ticks_next = '0;
                if (!receiving_reg)
                begin
                    if ((frame.sequence_req == 8'd0) && hit)
                    begin
                        receiving_next     = 1'b1;
                        active_stream_next = frame.channel_id;
                        remaining_next     = {frame.payload_0, frame.payload_1};
                        zero_len_next      = ({frame.payload_0, frame.payload_1} == 16'd0);
                        expected_seq_next  = 8'd1;
                    end
                end
                else if (frame.channel_id == active_stream_reg)
                begin
                    push = 1'b1;
                    if (frame.sequence_req == expected_seq_reg)
                    begin
                        cmd.kind          = KIND_DATA;
                        expected_seq_next = expected_seq_reg + 8'd1;
                        if (zero_len_reg)
                        begin
                            cmd.nbytes   = 3'd1;
                            cmd.complete = 1'b1;
                        end
                        else if (remaining_reg <= 16'(BYTES_PER_FRAME))
                        begin
                            cmd.nbytes     = remaining_reg[2:0];
                            cmd.complete   = 1'b1;
                            receiving_next = 1'b0;
                        end
                        else
                        begin
                            remaining_next = remaining_reg - 16'(BYTES_PER_FRAME);
                        end
                    end
                    else
                    begin
                        cmd.kind       = KIND_SEQ_ERR;
                        receiving_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg     <= 1'b0;
            active_stream_reg <= '0;
            expected_seq_reg  <= '0;
            remaining_reg     <= '0;
            zero_len_reg      <= 1'b0;
            idle_ticks_reg    <= '0;
        end
        else
        begin
            receiving_reg     <= receiving_next;
            active_stream_reg <= active_stream_next;
            expected_seq_reg  <= expected_seq_next;
            remaining_reg     <= remaining_next;
            zero_len_reg      <= zero_len_next;
            idle_ticks_reg    <= idle_ticks_next;
        end
    end

endmodule

// File: rtl/lmr_queue.sv
`timescale 1ns / 1ps

module lmr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lmr_pkg::cmd_t wr_data,
    output logic          full,
    output logic          rd_valid,
    output lmr_pkg::cmd_t rd_data,
    input  logic          rd_en
);
    import lmr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    cmd_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !(wr_en && count_next > count_reg))
        else $error("queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("queue count not advanced on push");

endmodule

// File: rtl/lmr_back.sv
`timescale 1ns / 1ps

module lmr_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  lmr_pkg::cmd_t   head,
    output logic            pop,
    input  logic [15:0]     chunk_length,
    output logic            result_valid,
    output lmr_pkg::result_t result,
    input  logic            result_stall
);
    import lmr_pkg::*;

    logic [2:0]  idx_reg, idx_next;
    logic [15:0] fill_reg, fill_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    logic        load;
    logic        step_last;
    logic [15:0] cnt;
    logic [2:0]  ev;

    assign load = head_valid && (!out_valid_reg || !result_stall);
    assign pop  = load && step_last;

    always_comb
    begin
        cnt       = fill_reg + 16'd1;
        ev        = EV_NONE;
        step_last = 1'b1;
        idx_next  = idx_reg;
        fill_next = fill_reg;
        out_next  = '0;
        case (head.kind)
            KIND_DATA:
            begin
                step_last = (3'(idx_reg + 3'd1) == head.nbytes);
                if (step_last && head.complete)
                    ev = EV_COMPLETE;
                else if (cnt >= chunk_length)
                    ev = EV_CHUNK;
                fill_next          = (ev != EV_NONE) ? '0 : cnt;
                out_next.has_byte  = 1'b1;
                out_next.data_byte = head.data[idx_reg];
            end
            KIND_SEQ_ERR:
            begin
                ev        = EV_SEQ_ERR;
                cnt       = fill_reg;
                fill_next = '0;
            end
            KIND_TIMEOUT:
            begin
                ev        = EV_TIMEOUT;
                cnt       = fill_reg;
                fill_next = '0;
            end
            default:
            begin
                ev        = EV_NONE;
                fill_next = fill_reg;
            end
        endcase
        idx_next              = step_last ? '0 : idx_reg + 3'd1;
        out_next.event_res    = ev;
        out_next.chunk_count  = (ev != EV_NONE) ? cnt : '0;
        out_next.event_stream = (ev != EV_NONE) ? head.stream : '0;
        out_next.last         = step_last;

        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!result_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                idx_reg  <= idx_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg < 3'(BYTES_PER_FRAME))
        else $error("byte index past frame");

    a_mid_frame_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> (head_valid && head.kind == KIND_DATA))
        else $error("frame entry lost mid-stream");

    a_eventless_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.has_byte) |-> result.last)
        else $error("event-only result not last");

endmodule

// File: tb/lmr_stream_checker.sv
`timescale 1ns / 1ps

module lmr_stream_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    input  lmr_pkg::frame_t  frame,
    input  logic             frame_stall,
    input  logic             result_valid,
    input  lmr_pkg::result_t result,
    input  logic             result_stall,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    output int               mismatches,
    output int               beats_owed
);
    import lmr_pkg::*;

    logic [15:0] tmo_limit;
    logic [15:0] chunk_len;
    logic [63:0] sub_ids;
    logic [3:0]  sub_cnt;

    logic        rx_open;
    logic [7:0]  rx_stream;
    logic [7:0]  next_seq;
    logic [15:0] msg_len;
    logic [15:0] rx_bytes;
    logic [15:0] fill;
    logic [15:0] idle;

    result_t     owed_beats[$];

    initial mismatches = 0;

    function automatic result_t make_beat(bit hb, logic [7:0] db, logic [2:0] ev,
                                          logic [15:0] cnt);
        result_t r;
        r.has_byte     = hb;
        r.data_byte    = db;
        r.event_res    = ev;
        r.chunk_count  = (ev != EV_NONE) ? cnt : 16'd0;
        r.event_stream = (ev != EV_NONE) ? rx_stream : 8'd0;
        r.last         = 1'b0;
        return r;
    endfunction

    task automatic close_rx();
        rx_open  = 1'b0;
        msg_len  = '0;
        rx_bytes = '0;
        fill     = '0;
    endtask

    task automatic reassemble(frame_t f);
        result_t     beats[BYTES_PER_FRAME];
        logic [7:0]  pay[BYTES_PER_FRAME];
        logic [2:0]  ev;
        logic [15:0] cnt;
        int          nb;
        int          n_ids;
        bit          listed;
        bit          done;
        nb = 0;
        pay[0] = f.payload_0;
        pay[1] = f.payload_1;
        pay[2] = f.payload_2;
        pay[3] = f.payload_3;
        pay[4] = f.payload_4;
        if (f.command)
        begin
            if (idle != 16'hFFFF)
                idle++;
            if (rx_open && idle >= tmo_limit)
            begin
                beats[nb++] = make_beat(1'b0, 8'd0, EV_TIMEOUT, fill);
                close_rx();
            end
        end
        else
        begin
            idle = '0;
            if (!rx_open)
            begin
                n_ids = (sub_cnt > 8) ? 8 : int'(sub_cnt);
                listed = 1'b0;
                for (int k = 0; k < n_ids; k++)
                    if (sub_ids[8*k +: 8] == f.channel_id)
                        listed = 1'b1;
                if (f.sequence_req == 8'd0 && listed)
                begin
                    rx_open   = 1'b1;
                    rx_stream = f.channel_id;
                    msg_len   = {f.payload_0, f.payload_1};
                    rx_bytes  = '0;
                    fill      = '0;
                    next_seq  = 8'd1;
                end
            end
            else if (f.channel_id == rx_stream)
            begin
                if (f.sequence_req == next_seq)
                begin
                    done = 1'b0;
                    for (int j = 0; j < BYTES_PER_FRAME && !done; j++)
                    begin
                        ev = EV_NONE;
                        fill++;
                        rx_bytes++;
                        cnt = fill;
                        if (rx_bytes >= msg_len)
                        begin
                            ev   = EV_COMPLETE;
                            fill = '0;
                            done = 1'b1;
                        end
                        else if (fill >= chunk_len)
                        begin
                            ev   = EV_CHUNK;
                            fill = '0;
                        end
                        beats[nb++] = make_beat(1'b1, pay[j], ev, cnt);
                    end
                    next_seq++;
                    if (msg_len != 0 && rx_bytes >= msg_len)
                        close_rx();
                end
                else
                begin
                    beats[nb++] = make_beat(1'b0, 8'd0, EV_SEQ_ERR, fill);
                    close_rx();
                end
            end
        end
        if (nb > 0)
            beats[nb-1].last = 1'b1;
        for (int k = 0; k < nb; k++)
            owed_beats.push_back(beats[k]);
    endtask

    function automatic int field_err(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    task automatic check_beat(result_t got);
        result_t want;
        if (owed_beats.size() == 0)
        begin
            $error("result beat with nothing pending: %p", got);
            mismatches++;
            return;
        end
        want = owed_beats.pop_front();
        mismatches += field_err("has_byte", 16'(want.has_byte), 16'(got.has_byte));
        mismatches += field_err("data_byte", 16'(want.data_byte), 16'(got.data_byte));
        mismatches += field_err("event_res", 16'(want.event_res), 16'(got.event_res));
        mismatches += field_err("chunk_count", want.chunk_count, got.chunk_count);
        mismatches += field_err("event_stream", 16'(want.event_stream),
                                16'(got.event_stream));
        mismatches += field_err("last", 16'(want.last), 16'(got.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_limit = TIMEOUT_TICKS_RESET;
            chunk_len = CHUNK_LENGTH_RESET;
            sub_ids   = '0;
            sub_cnt   = '0;
            close_rx();
            rx_stream = '0;
            next_seq  = '0;
            idle      = '0;
            owed_beats.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
                check_beat(result);
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_TIMEOUT_TICKS:    tmo_limit = cfg_data[15:0];
                    CFG_CHUNK_LENGTH:     chunk_len = cfg_data[15:0];
                    CFG_SUBSCRIBED_IDS:   sub_ids   = cfg_data;
                    CFG_SUBSCRIBED_COUNT: sub_cnt   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (frame_valid && !frame_stall)
                reassemble(frame);
        end
        beats_owed = owed_beats.size();
    end

endmodule

// File: tb/long_message_reassembler_unit_test.sv
`timescale 1ns / 1ps

module long_message_reassembler_unit_test;
    import lmr_pkg::*;

    localparam int LIMIT  = 400000;
    localparam int SETTLE = 40;

    logic        clk;
    logic        rst_n;
    logic        frame_valid;
    frame_t      frame;
    logic        frame_stall;
    logic        result_valid;
    result_t     result;
    logic        result_stall;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    int          mismatches;
    int          beats_owed;
    int          cycle_count;
    int          items_sent;
    int          burst_left;
    bit          hold_req;
    logic [15:0] tmo_cfg;
    logic [7:0]  id_list[$];

    long_message_reassembler_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame        (frame),
        .frame_stall  (frame_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    lmr_stream_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame        (frame),
        .frame_stall  (frame_stall),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .beats_owed   (beats_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // receiver: stall pattern in segments, plus a long hold on request
    initial
    begin
        int hold_left;
        int seg_left;
        int mode;
        hold_left = 0;
        seg_left = 0;
        mode = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    seg_left = $urandom_range(10, 80);
                end
                seg_left--;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic frame_t random_frame(logic cmd);
        logic [63:0] r;
        frame_t f;
        r = {$urandom(), $urandom()};
        f = r[$bits(frame_t)-1:0];
        f.command = cmd;
        return f;
    endfunction

    function automatic frame_t data_frame(logic [7:0] sid, logic [7:0] seq);
        frame_t f;
        f = random_frame(1'b0);
        f.channel_id = sid;
        f.sequence_req = seq;
        return f;
    endfunction

    function automatic frame_t header_frame(logic [7:0] sid, logic [15:0] len);
        frame_t f;
        f = data_frame(sid, 8'd0);
        f.payload_0 = len[15:8];
        f.payload_1 = len[7:0];
        return f;
    endfunction

    task automatic offer_frame(frame_t f);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                frame_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        frame <= f;
        frame_valid <= 1'b1;
        do @(posedge clk); while (frame_stall);
        items_sent++;
    endtask

    task automatic wait_drained(int settle);
        @(negedge clk);
        frame_valid <= 1'b0;
        while (beats_owed != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] tmo, logic [15:0] chunk, logic [63:0] ids,
                              logic [3:0] count);
        write_reg(CFG_TIMEOUT_TICKS, 64'(tmo));
        write_reg(CFG_CHUNK_LENGTH, 64'(chunk));
        write_reg(CFG_SUBSCRIBED_IDS, ids);
        write_reg(CFG_SUBSCRIBED_COUNT, 64'(count));
        tmo_cfg = tmo;
        id_list.delete();
        for (int k = 0; k < ((count > 8) ? 8 : int'(count)); k++)
            id_list.push_back(ids[8*k +: 8]);
    endtask

    task automatic send_ticks(int n);
        repeat (n) offer_frame(random_frame(1'b1));
    endtask

    task automatic send_message();
        logic [7:0]  sid;
        logic [7:0]  other;
        logic [7:0]  bad;
        logic [15:0] len;
        int          r;
        int          nfr;
        int          brk;
        int          cut;
        sid = id_list[$urandom_range(0, id_list.size() - 1)];
        r = $urandom_range(0, 19);
        len = (r == 0) ? 16'd0 : (r == 1) ? 16'($urandom_range(41, 300))
                                          : 16'($urandom_range(1, 40));
        offer_frame(header_frame(sid, len));
        nfr = (len == 0) ? $urandom_range(1, 3) : (int'(len) + 4) / 5;
        brk = $urandom_range(0, 9);
        cut = $urandom_range(0, nfr - 1);
        for (int i = 0; i < nfr; i++)
        begin
            if (brk == 0 && i == cut)
            begin
                bad = 8'(i + 1 + $urandom_range(1, 255));
                offer_frame(data_frame(sid, bad));
                return;
            end
            if (brk == 1 && i == cut && tmo_cfg <= 16)
            begin
                send_ticks((tmo_cfg == 0) ? 1 : int'(tmo_cfg));
                return;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                other = id_list[$urandom_range(0, id_list.size() - 1)];
                if (other == sid)
                    other = sid + 8'($urandom_range(1, 255));
                offer_frame(data_frame(other, ($urandom_range(0, 1) == 0) ? 8'd0
                                                : 8'($urandom_range(0, 255))));
            end
            if (tmo_cfg > 1 && $urandom_range(0, 9) == 0)
                send_ticks($urandom_range(1, (tmo_cfg > 4) ? 3 : int'(tmo_cfg) - 1));
            offer_frame(data_frame(sid, 8'(i + 1)));
        end
        // zero-length receptions never close by themselves
        if (len == 0)
            offer_frame(data_frame(sid, 8'(nfr + 1 + $urandom_range(1, 254))));
    endtask

    task automatic run_phase(int quota);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_message();
            else if (pick < 82)
                offer_frame(random_frame(1'b0));
            else if (pick < 86)
                offer_frame(header_frame(8'($urandom_range(0, 255)),
                                         16'($urandom_range(0, 65535))));
            else if (pick < 96)
                send_ticks($urandom_range(1, 4));
            else
                wait_drained(0);
        end
    endtask

    initial
    begin
        frame_t f;
        rst_n = 1'b0;
        frame_valid = 1'b0;
        frame = '0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_TIMEOUT_TICKS;
        cfg_data = '0;
        hold_req = 1'b0;
        items_sent = 0;
        burst_left = 0;
        tmo_cfg = TIMEOUT_TICKS_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // defaults: nothing subscribed
        send_ticks(1);
        offer_frame(header_frame(8'h00, 16'd5));
        wait_drained(SETTLE);

        set_config(16'd3, 16'd4, 64'h5656_5656_3400_FF12, 4'd3);
        offer_frame(data_frame(8'h12, 8'd5));
        offer_frame(header_frame(8'h12, 16'd12));
        offer_frame(header_frame(8'h00, 16'd5));
        f = data_frame(8'h12, 8'd1);
        {f.payload_0, f.payload_1, f.payload_2, f.payload_3, f.payload_4} = '0;
        offer_frame(f);
        f = data_frame(8'h12, 8'd2);
        {f.payload_0, f.payload_1, f.payload_2, f.payload_3, f.payload_4} = '1;
        offer_frame(f);
        offer_frame(data_frame(8'h12, 8'd3));
        offer_frame(header_frame(8'hFF, 16'd100));
        offer_frame(data_frame(8'hFF, 8'd1));
        send_ticks(3);
        offer_frame(header_frame(8'h00, 16'd50));
        offer_frame(data_frame(8'h00, 8'd2));
        offer_frame(header_frame(8'h12, 16'd9));
        offer_frame(data_frame(8'h12, 8'd1));
        offer_frame(data_frame(8'h12, 8'd0));
        offer_frame(header_frame(8'hFF, 16'd0));
        offer_frame(data_frame(8'hFF, 8'd1));
        offer_frame(data_frame(8'hFF, 8'd2));
        send_ticks(3);
        wait_drained(SETTLE);

        // zero chunk length, zero timeout, count beyond the table
        set_config(16'd0, 16'd0, 64'hAB00_0000_0000_0000, 4'd15);
        offer_frame(header_frame(8'hAB, 16'd7));
        offer_frame(data_frame(8'hAB, 8'd1));
        send_ticks(1);
        wait_drained(SETTLE);

        set_config(16'd6, 16'd7, {$urandom(), $urandom()}, 4'd4);
        hold_req = 1'b1;
        run_phase(60);
        wait_drained(SETTLE);

        set_config(16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
        // sequence numbers wrap through zero
        offer_frame(header_frame(8'hFF, 16'hFFFF));
        for (int i = 1; i <= 265; i++)
            offer_frame(data_frame(8'hFF, 8'(i)));
        offer_frame(data_frame(8'hFF, 8'd77));
        run_phase(60);
        wait_drained(SETTLE);

        set_config(16'd1, 16'd1, {$urandom(), $urandom()}, 4'd15);
        run_phase(60);
        wait_drained(SETTLE);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
